// ===== hdl/dbtc_pkg.sv =====
// Shared types, constants and helpers for the deadband thermostat controller.
// Depends on nothing; used by deadband_thermostat_controller, dbtc_checker and the testbench.
package dbtc_pkg;

    // Event codes carried in the op field
    typedef enum logic [1:0] {
        OpTick  = 2'd0,
        OpRaise = 2'd1,
        OpLower = 2'd2,
        OpPrime = 2'd3
    } op_t;

    // Control modes
    typedef enum logic [1:0] {
        ModeOff  = 2'd0,
        ModeCool = 2'd1,
        ModeHeat = 2'd2
    } mode_t;

    // Register indexes on the APB port
    typedef enum logic [1:0] {
        RegCheckPeriod = 2'd0,
        RegDeadband    = 2'd1,
        RegMinTarget   = 2'd2,
        RegMaxTarget   = 2'd3
    } reg_idx_t;

    localparam int unsigned AverageTapsDefault = 3;
    localparam int unsigned AdcW    = 12;
    localparam int unsigned TempW   = 9;
    localparam int unsigned PeriodW = 8;
    localparam int unsigned BandW   = 4;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    localparam int unsigned ScaleNum   = 330;
    localparam int unsigned ScaleShift = 12;
    localparam int unsigned ScaleNumW  = 9;

    localparam logic [TempW-1:0]   TargetReset      = 9'd30;
    localparam logic [PeriodW-1:0] CheckPeriodReset = 8'd5;
    localparam logic [BandW-1:0]   DeadbandReset    = 4'd1;
    localparam logic [TempW-1:0]   MinTargetReset   = 9'd5;
    localparam logic [TempW-1:0]   MaxTargetReset   = 9'd40;

    // Raw converter value to whole degrees: floor(x * 330 / 4096)
    function automatic logic [TempW-1:0] scale_sample(input logic [AdcW-1:0] raw);
        logic [AdcW+ScaleNumW-1:0] prod;
        prod = (AdcW+ScaleNumW)'(raw) * (AdcW+ScaleNumW)'(ScaleNum);
        return prod[ScaleShift +: TempW];
    endfunction

endpackage

// ===== hdl/deadband_thermostat_controller.sv =====
// Deadband thermostat controller: event decode, reading ring, averaging and mode choice.
// Depends on dbtc_pkg for event and mode codes, register indexes and sample scaling.
// An accepted word is held in the input stage, then its result is registered in the result
// register. Throughput: one word per cycle while out_ready holds; the input stage and the
// result register form a two-stage pipeline, and each word updates the state in a single pass.
// Reset (rst_n low, asynchronous): registers to their defaults, target 30, ring zero, mode off.
module deadband_thermostat_controller #(
    parameter int unsigned AVERAGE_TAPS = dbtc_pkg::AverageTapsDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [dbtc_pkg::AdcW-1:0]    adc_sample,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   mode,
    output logic [dbtc_pkg::TempW-1:0]   average_temp,
    output logic [dbtc_pkg::TempW-1:0]   target_temp,
    output logic                         check_done,
    output logic                         cool_drive,
    output logic                         heat_drive,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dbtc_pkg::AddrW-1:0]   paddr,
    input  logic [dbtc_pkg::DataW-1:0]   pwdata,
    output logic [dbtc_pkg::DataW-1:0]   prdata,
    output logic                         pready
);

    localparam int unsigned TempW     = dbtc_pkg::TempW;
    localparam int unsigned PeriodW   = dbtc_pkg::PeriodW;
    localparam int unsigned BandW     = dbtc_pkg::BandW;
    localparam int unsigned DataW     = dbtc_pkg::DataW;
    localparam int unsigned SlotW     = $clog2(AVERAGE_TAPS);
    localparam int unsigned SumW      = TempW + $clog2(AVERAGE_TAPS);
    // reciprocal for the divide by tap count; exact for sums below 2**SumW
    localparam int unsigned RecipShift = SumW + 8;
    localparam int unsigned RecipW     = RecipShift + 1;
    localparam int unsigned RecipMul   = ((1 << RecipShift) + AVERAGE_TAPS - 1) / AVERAGE_TAPS;
    localparam int unsigned ProdW      = SumW + RecipW;

    // ---------------- configuration registers ----------------
    logic [PeriodW-1:0] check_period_reg;
    logic [BandW-1:0]   deadband_reg;
    logic [TempW-1:0]   min_target_reg;
    logic [TempW-1:0]   max_target_reg;
    logic               cfg_write;
    dbtc_pkg::reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = dbtc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_period_reg <= dbtc_pkg::CheckPeriodReset;
            deadband_reg     <= dbtc_pkg::DeadbandReset;
            min_target_reg   <= dbtc_pkg::MinTargetReset;
            max_target_reg   <= dbtc_pkg::MaxTargetReset;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                dbtc_pkg::RegCheckPeriod: check_period_reg <= pwdata[PeriodW-1:0];
                dbtc_pkg::RegDeadband:    deadband_reg     <= pwdata[BandW-1:0];
                dbtc_pkg::RegMinTarget:   min_target_reg   <= pwdata[TempW-1:0];
                dbtc_pkg::RegMaxTarget:   max_target_reg   <= pwdata[TempW-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (cfg_idx)
            dbtc_pkg::RegCheckPeriod: prdata = DataW'(check_period_reg);
            dbtc_pkg::RegDeadband:    prdata = DataW'(deadband_reg);
            dbtc_pkg::RegMinTarget:   prdata = DataW'(min_target_reg);
            dbtc_pkg::RegMaxTarget:   prdata = DataW'(max_target_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic               s1_valid_reg;
    dbtc_pkg::op_t      s1_op_reg;
    logic [TempW-1:0]   s1_reading_reg;
    logic               out_valid_reg;
    logic               in_fire;
    logic               s2_fire;

    assign s2_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_fire;
    assign in_fire  = in_valid && in_ready;

    // input stage: event and scaled reading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg      <= dbtc_pkg::op_t'(op);
            s1_reading_reg <= dbtc_pkg::scale_sample(adc_sample);
        end
    end

    // ---------------- controller state ----------------
    logic [TempW-1:0]   target_reg,  target_next;
    logic [TempW-1:0]   ring_reg     [AVERAGE_TAPS];
    logic [TempW-1:0]   ring_next    [AVERAGE_TAPS];
    logic [SlotW-1:0]   slot_reg,    slot_next;
    logic [PeriodW-1:0] phase_reg,   phase_next;
    logic               gate_reg,    gate_next;
    dbtc_pkg::mode_t    mode_reg,    mode_next;
    logic [TempW-1:0]   avg_reg,     avg_next;
    logic               check_next;

    logic [SlotW-1:0]   slot_adv;
    logic [PeriodW:0]   phase_inc;
    logic [PeriodW:0]   period_eff;
    logic               check_due;
    logic [SumW-1:0]    ring_sum;
    logic [ProdW-1:0]   avg_prod;
    logic [TempW-1:0]   tick_avg;
    logic [TempW:0]     diff_up;
    logic [TempW:0]     diff_dn;
    dbtc_pkg::mode_t    tick_mode;

    assign slot_adv   = (slot_reg == SlotW'(AVERAGE_TAPS - 1)) ? '0 : slot_reg + 1'b1;
    assign phase_inc  = {1'b0, phase_reg} + 1'b1;
    assign period_eff = {1'b0, (check_period_reg == '0) ? PeriodW'(1) : check_period_reg};
    assign check_due  = (phase_inc >= period_eff);

    // ring sum with the new reading in the advanced slot
    always_comb
    begin
        ring_sum = '0;
        for (int i = 0; i < AVERAGE_TAPS; i++)
        begin
            if (slot_adv == SlotW'(i))
                ring_sum = ring_sum + SumW'(s1_reading_reg);
            else
                ring_sum = ring_sum + SumW'(ring_reg[i]);
        end
    end

    // truncating average via reciprocal multiply
    assign avg_prod = ProdW'(ring_sum) * ProdW'(RecipMul);
    assign tick_avg = avg_prod[RecipShift +: TempW];

    // deadband compare
    assign diff_up = {1'b0, tick_avg} - {1'b0, target_reg};
    assign diff_dn = {1'b0, target_reg} - {1'b0, tick_avg};

    always_comb
    begin
        if (tick_avg >= target_reg)
            tick_mode = (diff_up <= (TempW+1)'(deadband_reg)) ? dbtc_pkg::ModeOff
                                                               : dbtc_pkg::ModeCool;
        else
            tick_mode = (diff_dn <= (TempW+1)'(deadband_reg)) ? dbtc_pkg::ModeOff
                                                               : dbtc_pkg::ModeHeat;
    end

    // next state for the word in the input stage
    always_comb
    begin
        target_next = target_reg;
        ring_next   = ring_reg;
        slot_next   = slot_reg;
        phase_next  = phase_reg;
        gate_next   = gate_reg;
        mode_next   = mode_reg;
        avg_next    = avg_reg;
        check_next  = 1'b0;
        case (s1_op_reg)
            dbtc_pkg::OpTick:
            begin
                gate_next = 1'b1;
                if (check_due)
                begin
                    phase_next          = '0;
                    slot_next           = slot_adv;
                    ring_next[slot_adv] = s1_reading_reg;
                    avg_next            = tick_avg;
                    mode_next           = tick_mode;
                    check_next          = 1'b1;
                end
                else
                begin
                    phase_next = phase_inc[PeriodW-1:0];
                end
            end
            dbtc_pkg::OpRaise:
            begin
                if (gate_reg)
                begin
                    gate_next = 1'b0;
                    if (max_target_reg > target_reg)
                        target_next = target_reg + 1'b1;
                end
            end
            dbtc_pkg::OpLower:
            begin
                if (gate_reg)
                begin
                    gate_next = 1'b0;
                    if (min_target_reg < target_reg)
                        target_next = target_reg - 1'b1;
                end
            end
            dbtc_pkg::OpPrime:
            begin
                // every slot holds the same reading, so it is the average
                for (int i = 0; i < AVERAGE_TAPS; i++)
                    ring_next[i] = s1_reading_reg;
                avg_next = s1_reading_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= dbtc_pkg::TargetReset;
            for (int i = 0; i < AVERAGE_TAPS; i++)
                ring_reg[i] <= '0;
            slot_reg   <= '0;
            phase_reg  <= '0;
            gate_reg   <= 1'b0;
            mode_reg   <= dbtc_pkg::ModeOff;
            avg_reg    <= '0;
        end
        else if (s2_fire)
        begin
            target_reg <= target_next;
            ring_reg   <= ring_next;
            slot_reg   <= slot_next;
            phase_reg  <= phase_next;
            gate_reg   <= gate_next;
            mode_reg   <= mode_next;
            avg_reg    <= avg_next;
        end
    end

    // ---------------- result register ----------------
    logic [1:0]       mode_out_reg;
    logic [TempW-1:0] avg_out_reg;
    logic [TempW-1:0] target_out_reg;
    logic             check_out_reg;
    logic             cool_out_reg;
    logic             heat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            mode_out_reg   <= mode_next;
            avg_out_reg    <= avg_next;
            target_out_reg <= target_next;
            check_out_reg  <= check_next;
            cool_out_reg   <= (mode_next == dbtc_pkg::ModeCool);
            heat_out_reg   <= (mode_next == dbtc_pkg::ModeHeat);
        end
    end

    assign out_valid    = out_valid_reg;
    assign mode         = mode_out_reg;
    assign average_temp = avg_out_reg;
    assign target_temp  = target_out_reg;
    assign check_done   = check_out_reg;
    assign cool_drive   = cool_out_reg;
    assign heat_drive   = heat_out_reg;

    // ---------------- checks ----------------
    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(cool_out_reg && heat_out_reg))
        else $error("cooling and heating driven together");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SlotW'(AVERAGE_TAPS - 1))
        else $error("ring slot beyond tap count");

    a_phase_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && check_next) |=> (phase_reg == '0))
        else $error("tick phase not cleared after a check");

    a_target_by_press: assert property (@(posedge clk) disable iff (!rst_n)
        (target_reg != $past(target_reg)) |->
            ($past(s2_fire) && $past(gate_reg) &&
             ($past(s1_op_reg) == dbtc_pkg::OpRaise || $past(s1_op_reg) == dbtc_pkg::OpLower)))
        else $error("target moved without an accepted press");

    a_check_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && s1_op_reg != dbtc_pkg::OpTick) |=> !check_out_reg)
        else $error("check reported for a non-tick word");

endmodule

// ===== dv/dbtc_checker.sv =====
// Checker for the deadband thermostat controller: mirrors the thermostat state, predicts
// each result word and compares it; also checks register read-back on the APB port.
// Depends on dbtc_pkg for event and mode codes, register indexes and field widths.
module dbtc_checker #(
    parameter int unsigned TAPS = dbtc_pkg::AverageTapsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [dbtc_pkg::AdcW-1:0]     adc_sample,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [1:0]                    mode,
    input  logic [dbtc_pkg::TempW-1:0]    average_temp,
    input  logic [dbtc_pkg::TempW-1:0]    target_temp,
    input  logic                          check_done,
    input  logic                          cool_drive,
    input  logic                          heat_drive,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbtc_pkg::AddrW-1:0]    paddr,
    input  logic [dbtc_pkg::DataW-1:0]    pwdata,
    input  logic [dbtc_pkg::DataW-1:0]    prdata,
    input  logic                          pready,
    output int                            errors,
    output int                            pending,
    output int                            checks,
    output int                            presses
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TempW   = dbtc_pkg::TempW;
    localparam int unsigned PeriodW = dbtc_pkg::PeriodW;
    localparam int unsigned BandW   = dbtc_pkg::BandW;
    localparam int unsigned AdcW    = dbtc_pkg::AdcW;
    localparam int unsigned DataW   = dbtc_pkg::DataW;

    typedef struct packed {
        dbtc_pkg::mode_t  mode;
        logic [TempW-1:0] avg;
        logic [TempW-1:0] target;
        logic             done;
        logic             cool;
        logic             heat;
    } thermo_word_t;

    // Register copies
    logic [PeriodW-1:0] cfg_period;
    logic [BandW-1:0]   cfg_band;
    logic [TempW-1:0]   cfg_min;
    logic [TempW-1:0]   cfg_max;

    // Thermostat state copy
    logic [TempW-1:0]   set_point;
    logic [TempW-1:0]   readings [TAPS];
    int unsigned        slot;
    logic [PeriodW-1:0] phase;
    logic               armed;
    dbtc_pkg::mode_t    cur_mode;
    logic [TempW-1:0]   cur_avg;

    // Result words still to come, oldest first
    thermo_word_t due_words[$];

    function automatic logic [TempW-1:0] to_degrees(logic [AdcW-1:0] raw);
        int unsigned x;
        x = raw;
        return TempW'((x * dbtc_pkg::ScaleNum) >> dbtc_pkg::ScaleShift);
    endfunction

    function automatic void refresh_average();
        int unsigned sum;
        sum = 0;
        foreach (readings[i])
            sum += readings[i];
        cur_avg = TempW'(sum / TAPS);
    endfunction

    // Off inside the band, cooling above it, heating below
    function automatic void pick_mode();
        int a;
        int t;
        int b;
        a = cur_avg;
        t = set_point;
        b = cfg_band;
        if (a + b >= t && a - b <= t)
            cur_mode = dbtc_pkg::ModeOff;
        else if (a > t)
            cur_mode = dbtc_pkg::ModeCool;
        else
            cur_mode = dbtc_pkg::ModeHeat;
    endfunction

    // Advance the state by one event and return the word it should produce
    function automatic thermo_word_t apply_event(dbtc_pkg::op_t kind, logic [AdcW-1:0] sample);
        thermo_word_t w;
        int unsigned span;
        logic [TempW-1:0] deg;
        w.done = 1'b0;
        case (kind)
            dbtc_pkg::OpTick:
            begin
                // a zero period behaves as one
                span = (cfg_period == '0) ? 1 : cfg_period;
                armed = 1'b1;
                if (32'(phase) + 1 >= span)
                begin
                    phase = '0;
                    slot = (slot + 1) % TAPS;
                    readings[slot] = to_degrees(sample);
                    refresh_average();
                    pick_mode();
                    w.done = 1'b1;
                end
                else
                begin
                    phase = phase + 1'b1;
                end
            end
            dbtc_pkg::OpRaise:
            begin
                if (armed)
                begin
                    armed = 1'b0;
                    presses++;
                    if (cfg_max > set_point)
                        set_point = set_point + 1'b1;
                end
            end
            dbtc_pkg::OpLower:
            begin
                if (armed)
                begin
                    armed = 1'b0;
                    presses++;
                    if (cfg_min < set_point)
                        set_point = set_point - 1'b1;
                end
            end
            default:
            begin
                // prime: every slot takes the reading, mode left alone
                deg = to_degrees(sample);
                foreach (readings[i])
                    readings[i] = deg;
                refresh_average();
            end
        endcase
        w.mode   = cur_mode;
        w.avg    = cur_avg;
        w.target = set_point;
        w.cool   = (cur_mode == dbtc_pkg::ModeCool);
        w.heat   = (cur_mode == dbtc_pkg::ModeHeat);
        return w;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        thermo_word_t got;
        thermo_word_t want;
        thermo_word_t next_word;
        logic [DataW-1:0] reg_value;
        if (!rst_n)
        begin
            cfg_period = dbtc_pkg::CheckPeriodReset;
            cfg_band   = dbtc_pkg::DeadbandReset;
            cfg_min    = dbtc_pkg::MinTargetReset;
            cfg_max    = dbtc_pkg::MaxTargetReset;
            set_point  = dbtc_pkg::TargetReset;
            foreach (readings[i])
                readings[i] = '0;
            slot     = 0;
            phase    = '0;
            armed    = 1'b0;
            cur_mode = dbtc_pkg::ModeOff;
            cur_avg  = '0;
            due_words.delete();
            errors  = 0;
            pending = 0;
            checks  = 0;
            presses = 0;
        end
        else
        begin
            // Register writes and read-back
            if (psel && penable && pready && pwrite)
            begin
                case (dbtc_pkg::reg_idx_t'(paddr[3:2]))
                    dbtc_pkg::RegCheckPeriod: cfg_period = pwdata[PeriodW-1:0];
                    dbtc_pkg::RegDeadband:    cfg_band   = pwdata[BandW-1:0];
                    dbtc_pkg::RegMinTarget:   cfg_min    = pwdata[TempW-1:0];
                    default:                  cfg_max    = pwdata[TempW-1:0];
                endcase
            end
            if (psel && penable && pready && !pwrite)
            begin
                case (dbtc_pkg::reg_idx_t'(paddr[3:2]))
                    dbtc_pkg::RegCheckPeriod: reg_value = DataW'(cfg_period);
                    dbtc_pkg::RegDeadband:    reg_value = DataW'(cfg_band);
                    dbtc_pkg::RegMinTarget:   reg_value = DataW'(cfg_min);
                    default:                  reg_value = DataW'(cfg_max);
                endcase
                if (prdata !== reg_value)
                    flag_mismatch("register read-back", prdata, reg_value);
            end

            // Result words against the oldest prediction
            if (out_valid && out_ready)
            begin
                got.mode   = dbtc_pkg::mode_t'(mode);
                got.avg    = average_temp;
                got.target = target_temp;
                got.done   = check_done;
                got.cool   = cool_drive;
                got.heat   = heat_drive;
                if (due_words.size() == 0)
                    flag_mismatch("result word with nothing expected", 0, 0);
                else
                begin
                    want = due_words.pop_front();
                    if (got.mode !== want.mode)
                        flag_mismatch("mode", got.mode, want.mode);
                    if (got.avg !== want.avg)
                        flag_mismatch("average_temp", got.avg, want.avg);
                    if (got.target !== want.target)
                        flag_mismatch("target_temp", got.target, want.target);
                    if (got.done !== want.done)
                        flag_mismatch("check_done", got.done, want.done);
                    if (got.cool !== want.cool)
                        flag_mismatch("cool_drive", got.cool, want.cool);
                    if (got.heat !== want.heat)
                        flag_mismatch("heat_drive", got.heat, want.heat);
                end
            end

            // Accepted input word
            if (in_valid && in_ready)
            begin
                next_word = apply_event(dbtc_pkg::op_t'(op), adc_sample);
                if (next_word.done)
                    checks++;
                due_words.push_back(next_word);
            end
            pending = due_words.size();
        end
    end

endmodule

// ===== dv/tb_deadband_thermostat_controller.sv =====
// Testbench top for the deadband thermostat controller: clock, reset, event words,
// register settings and the verdict. Depends on dbtc_pkg, the controller and dbtc_checker.
module tb_deadband_thermostat_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned AdcW  = dbtc_pkg::AdcW;
    localparam int unsigned TempW = dbtc_pkg::TempW;
    localparam int unsigned AddrW = dbtc_pkg::AddrW;
    localparam int unsigned DataW = dbtc_pkg::DataW;

    localparam int CycleLimit  = 400000;
    localparam int PhaseWords  = 90;
    localparam int PhaseCount  = 10;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [AdcW-1:0]    adc_sample;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         mode;
    logic [TempW-1:0]   average_temp;
    logic [TempW-1:0]   target_temp;
    logic               check_done;
    logic               cool_drive;
    logic               heat_drive;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [DataW-1:0]   pwdata;
    logic [DataW-1:0]   prdata;
    logic               pready;

    int errors;
    int pending;
    int checks;
    int presses;

    int          cycles;
    int          words_sent;
    int          settings_used;
    int unsigned gap_odds;
    int unsigned stall_odds;
    int unsigned aim_degrees;
    bit          quiet;

    deadband_thermostat_controller dut (.*);

    dbtc_checker u_checker (.*);

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stall bursts unless quiet
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(99) < stall_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Offer one word from a falling edge; return at the falling edge after acceptance, or after a random idle gap
    task automatic send_word(dbtc_pkg::op_t kind, logic [AdcW-1:0] sample);
        in_valid   <= 1'b1;
        op         <= kind;
        adc_sample <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        words_sent++;
        if (!quiet && $urandom_range(99) < gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result word
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write followed by a read of the same register
    task automatic set_register(dbtc_pkg::reg_idx_t idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(int unsigned period, int unsigned band,
                                  int unsigned lo, int unsigned hi);
        drain();
        set_register(dbtc_pkg::RegCheckPeriod, period);
        set_register(dbtc_pkg::RegDeadband, band);
        set_register(dbtc_pkg::RegMinTarget, lo);
        set_register(dbtc_pkg::RegMaxTarget, hi);
        aim_degrees = (lo + hi) / 2;
        settings_used++;
    endtask

    // Mostly ticks; presses often enough to hit the gate and the limits
    function automatic dbtc_pkg::op_t pick_op();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return dbtc_pkg::OpTick;
        else if (roll < 73)
            return dbtc_pkg::OpRaise;
        else if (roll < 91)
            return dbtc_pkg::OpLower;
        return dbtc_pkg::OpPrime;
    endfunction

    // Half the samples land near the middle of the target range so all modes occur
    function automatic logic [AdcW-1:0] pick_sample();
        int          spot;
        int unsigned roll;
        roll = $urandom_range(99);
        spot = int'(aim_degrees * 4096 / 330) + int'($urandom_range(400)) - 200;
        if (roll < 50)
        begin
            if (spot < 0)
                spot = 0;
            if (spot > 4095)
                spot = 4095;
            return AdcW'(spot);
        end
        if (roll < 60)
            return roll[0] ? '1 : '0;
        return AdcW'($urandom_range(4095));
    endfunction

    initial
    begin
        int unsigned period;
        int unsigned band;
        int unsigned lo;
        int unsigned hi;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = dbtc_pkg::OpTick;
        adc_sample  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        words_sent  = 0;
        settings_used = 0;
        gap_odds    = 20;
        stall_odds  = 20;
        aim_degrees = 22;
        quiet       = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Presses before any tick are ignored; prime at both sample extremes
        send_word(dbtc_pkg::OpRaise, 12'h000);
        send_word(dbtc_pkg::OpLower, 12'hFFF);
        send_word(dbtc_pkg::OpPrime, 12'hFFF);
        send_word(dbtc_pkg::OpPrime, 12'h000);
        // Default period of five: the fifth tick checks, into the second slot
        send_word(dbtc_pkg::OpTick, 12'hFFF);
        send_word(dbtc_pkg::OpTick, 12'h000);
        send_word(dbtc_pkg::OpTick, 12'hAAA);
        send_word(dbtc_pkg::OpTick, 12'h555);
        send_word(dbtc_pkg::OpTick, 12'hFFF);
        // One press per tick: the second raise is ignored
        send_word(dbtc_pkg::OpRaise, 12'h000);
        send_word(dbtc_pkg::OpRaise, 12'h000);
        send_word(dbtc_pkg::OpTick, 12'h000);
        send_word(dbtc_pkg::OpLower, 12'h000);

        // Zero period checks on every tick; widest band
        apply_settings(0, 15, 0, 329);
        send_word(dbtc_pkg::OpTick, 12'h000);
        send_word(dbtc_pkg::OpTick, 12'hFFF);
        send_word(dbtc_pkg::OpTick, 12'h7FF);
        send_word(dbtc_pkg::OpPrime, 12'h1A2);

        // Target outside both limits: presses in either direction leave it
        apply_settings(200, 0, 40, 0);
        send_word(dbtc_pkg::OpTick, 12'h123);
        send_word(dbtc_pkg::OpRaise, 12'h000);
        send_word(dbtc_pkg::OpTick, 12'h456);
        send_word(dbtc_pkg::OpLower, 12'h000);
        send_word(dbtc_pkg::OpTick, 12'h789);

        // Phase already past the new period: next tick checks
        apply_settings(2, 0, 40, 0);
        send_word(dbtc_pkg::OpTick, 12'hFFF);
        send_word(dbtc_pkg::OpTick, 12'h000);

        // Random phases over a spread of settings
        for (int p = 0; p < PhaseCount; p++)
        begin
            case (p)
                0: begin period = 1;   band = 0;  lo = 0;   hi = 329; end
                1: begin period = 0;   band = 15; lo = 0;   hi = 329; end
                2: begin period = 3;   band = 2;  lo = 20;  hi = 60;  end
                3: begin period = 255; band = 5;  lo = 10;  hi = 20;  end
                4: begin period = 2;   band = 1;  lo = 300; hi = 329; end
                5: begin period = 1;   band = 3;  lo = 0;   hi = 10;  end
                default:
                begin
                    period = $urandom_range(1, 6);
                    band   = $urandom_range(15);
                    lo     = $urandom_range(200);
                    hi     = lo + $urandom_range(129);
                end
            endcase
            // last phase runs flat out on both sides
            if (p == PhaseCount - 1)
                quiet = 1'b1;
            gap_odds   = (p % 4 == 1) ? 0 : $urandom_range(5, 30);
            stall_odds = (p % 4 == 2) ? 0 : $urandom_range(5, 30);
            apply_settings(period, band, lo, hi);
            for (int n = 0; n < PhaseWords; n++)
            begin
                if (n == PhaseWords / 2 && p % 3 == 0)
                    drain();
                send_word(pick_op(), pick_sample());
            end
        end

        drain();

        $display("Run covered %0d event words under %0d register settings,", words_sent,
                 settings_used);
        $display("with %0d temperature checks and %0d accepted presses.", checks, presses);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dbtc_pkg.sv
hdl/deadband_thermostat_controller.sv
dv/dbtc_checker.sv
dv/tb_deadband_thermostat_controller.sv
